// File: rtl/core/bfie_pkg.sv
// shared types, constants and helpers for the bit-field insert/extract block
// no dependencies
package bfie_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int WORD_BITS     = 64;
    localparam int SPAN_BYTES    = 9;                        // bytes a 64-bit field can touch
    localparam int ACC_W         = SPAN_BYTES * BYTE_BITS;
    localparam int CMD_W         = 2;
    localparam int OFF_W         = 11;
    localparam int LEN_W         = 7;
    localparam int VB_W          = 9;
    localparam int SH_W          = 3;
    localparam int IDX_W         = OFF_W - SH_W + 1;         // byte index incl. span overrun
    localparam int CNT_W         = 4;
    localparam int DEF_BUF_BYTES = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ_U = 2'd1,
        CMD_READ_S = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // control from the sequencer to the byte lane
    typedef struct packed {
        logic load;      // take a new transaction
        logic shift;     // a buffer byte is back from memory
        logic rd_ok;     // that byte lies inside the readable range
    } t_lane_ctl;

    // low len bits set, len already limited to WORD_BITS
    function automatic logic [WORD_BITS-1:0] ones(input logic [LEN_W-1:0] len);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : len;
    endfunction

endpackage

// File: rtl/core/bfie_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bfie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bfie_lane.sv
// byte-serial datapath: write data and mask shift out a byte at a time,
// read bytes shift into an accumulator; final alignment and sign extension
// depends on bfie_pkg
module bfie_lane import bfie_pkg::*; (
    input  logic                 i_clk,
    input  t_lane_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_value,
    input  logic [LEN_W-1:0]     i_len,
    input  logic [SH_W-1:0]      i_sh,
    input  logic                 i_signed,
    input  logic [BYTE_BITS-1:0] i_ram_byte,
    output logic [BYTE_BITS-1:0] o_wr_byte,
    output logic [WORD_BITS-1:0] o_result
);

    logic [ACC_W-1:0]     r_data;
    logic [ACC_W-1:0]     r_mask;
    logic [ACC_W-1:0]     r_acc;
    logic [LEN_W-1:0]     r_len;
    logic [SH_W-1:0]      r_sh;
    logic                 r_signed;
    logic [BYTE_BITS-1:0] rd_byte;
    logic [ACC_W-1:0]     acc_sh;
    logic [WORD_BITS-1:0] len_mask;
    logic [WORD_BITS-1:0] field;
    logic                 sign_bit;

    assign rd_byte = i_ctl.rd_ok ? i_ram_byte : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data   <= ACC_W'(i_value & ones(i_len)) << i_sh;
            r_mask   <= ACC_W'(ones(i_len)) << i_sh;
            r_len    <= i_len;
            r_sh     <= i_sh;
            r_signed <= i_signed;
        end else if (i_ctl.shift) begin
            r_data <= r_data >> BYTE_BITS;
            r_mask <= r_mask >> BYTE_BITS;
            r_acc  <= {rd_byte, r_acc[ACC_W-1:BYTE_BITS]};
        end
    end

    // read-modify-write merge of the current byte
    assign o_wr_byte = (i_ram_byte & ~r_mask[BYTE_BITS-1:0])
                     | (r_data[BYTE_BITS-1:0] & r_mask[BYTE_BITS-1:0]);

    assign acc_sh   = r_acc >> r_sh;
    assign len_mask = ones(r_len);
    assign field    = acc_sh[WORD_BITS-1:0] & len_mask;
    assign sign_bit = (r_len != '0) && field[6'(r_len - LEN_W'(1))];
    assign o_result = (r_signed && sign_bit) ? (field | ~len_mask) : field;

endmodule

// File: rtl/core/bit_field_buffer_insert_extract.sv
// top level of the bit-field insert/extract block: sequencer, buffer memory, byte lane
// depends on bfie_pkg, bfie_ram, bfie_lane
//
// Keeps a BUF_BYTES byte buffer and runs one command per transaction on a field
// of 0..64 bits at any bit offset, lsb first within each byte. A write merges the
// low field_length bits of write_value into the buffer; a read returns the field
// zero- or sign-extended, with bits in bytes at or past valid_bytes reading zero.
// The field always moves through the buffer memory one byte per cycle over a fixed
// nine-byte window (one read-modify-write per cycle on the single write port of
// the byte-wide memory, plus an alignment state for reads). Command 3 is accepted
// without leaving idle and has no effect. After reset the buffer is zeroed by a
// clearing pass over all BUF_BYTES bytes, during which o_stall stays high. The
// input side is accepted again while a read result still waits in the output
// register.
module bit_field_buffer_insert_extract import bfie_pkg::*; #(
    parameter int BUF_BYTES = DEF_BUF_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [OFF_W-1:0]     i_bit_offset,
    input  logic [LEN_W-1:0]     i_field_length,
    input  logic [WORD_BITS-1:0] i_write_value,
    input  logic [VB_W-1:0]      i_valid_bytes,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_read_value
);

    localparam int AW = $clog2(BUF_BYTES);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr;
    logic [CNT_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_base;
    logic [VB_W-1:0]      r_vbytes;
    logic                 r_write;
    logic [AW-1:0]        r_prev_addr;
    logic                 r_prev_wr_ok;     // previous byte inside the buffer
    logic                 r_prev_rd_ok;     // ... and inside the valid byte count
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_read_value;

    logic                 in_take;
    logic                 out_free;
    logic [IDX_W-1:0]     idx;
    logic                 idx_in_buf;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [BYTE_BITS-1:0] ram_wdata;
    logic [BYTE_BITS-1:0] ram_rdata;
    logic [BYTE_BITS-1:0] wr_byte;
    logic [WORD_BITS-1:0] result;
    logic                 byte_back;
    t_lane_ctl            lane_ctl;
    t_cmd                 cmd;

    assign cmd      = t_cmd'(i_command);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // current byte of the nine-byte window
    assign idx        = r_base + IDX_W'(r_cnt);
    assign idx_in_buf = (32'(idx) < 32'(BUF_BYTES));
    // data for byte r_cnt-1 comes back from memory this cycle
    assign byte_back  = (r_state == ST_RUN) && (r_cnt != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(BUF_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take && cmd != CMD_NONE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_W'(SPAN_BYTES)) begin
                    n_state = r_write ? ST_IDLE : ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (in_take) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction fields and the registered memory pipeline
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_base   <= IDX_W'(i_bit_offset[OFF_W-1:SH_W]);
            r_vbytes <= i_valid_bytes;
            r_write  <= (cmd == CMD_WRITE);
        end
        r_prev_addr  <= AW'(idx);
        r_prev_wr_ok <= idx_in_buf;
        r_prev_rd_ok <= idx_in_buf && (idx < IDX_W'(r_vbytes));
        if (r_state == ST_FIN && out_free) begin
            r_read_value <= result;
        end
    end

    // memory write: zeros while clearing, merged byte during a write command
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_prev_addr;
        ram_wdata = wr_byte;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (byte_back && r_write && r_prev_wr_ok) begin
            ram_we = 1'b1;
        end
    end

    bfie_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (BUF_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(idx)),
        .o_rdata (ram_rdata)
    );

    assign lane_ctl.load  = in_take;
    assign lane_ctl.shift = byte_back;
    assign lane_ctl.rd_ok = r_prev_rd_ok;

    bfie_lane u_lane (
        .i_clk      (i_clk),
        .i_ctl      (lane_ctl),
        .i_value    (i_write_value),
        .i_len      (clamp_len(i_field_length)),
        .i_sh       (i_bit_offset[SH_W-1:0]),
        .i_signed   (cmd == CMD_READ_S),
        .i_ram_byte (ram_rdata),
        .o_wr_byte  (wr_byte),
        .o_result   (result)
    );

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;

    // memory is only written while clearing or running a write
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FIN) |-> !ram_we)
        else $error("buffer written outside a write transaction");

    // a result only appears after the alignment cycle of a read
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result raised without a finished read");

    // byte counter stays inside the nine-byte window
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_cnt <= CNT_W'(SPAN_BYTES)))
        else $error("byte counter overran the window");

    // no result can exist while the buffer is still being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result pending during clearing pass");

endmodule
